// File: rtl/hgm_pkg.sv
// Package for the gray-level histogram engine: shared constants, the command
// opcode type and the control word that travels from the front end to the back end.
// No dependencies.
package hgm_pkg;

	localparam int MAX_BINS_DEF        = 256;
	localparam int PIXEL_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH         = 4;

	localparam int COUNT_W = 32;
	localparam int BINS_W  = 9;
	localparam int INDEX_W = 8;

	localparam logic [BINS_W-1:0] BINS_RESET = 9'd256;

	typedef enum logic {
		HGM_OP_ACCUM = 1'b0,
		HGM_OP_READ  = 1'b1
	} hgm_op_t;

	// Control half of one queued command; the bin address travels beside it.
	typedef struct packed {
		hgm_op_t op;
		logic    in_range;
	} hgm_ctl_t;

endpackage

// File: rtl/gray_level_histogram.sv
// Top level of the gray-level histogram engine: front end, command queue and
// back end. Uses hgm_pkg, hgm_front, hgm_fifo and hgm_back.
//
// A command is transferred at a rising edge where start is high and busy is low.
// With op at accumulate, pixel_code (unsigned, 1 << PIXEL_FRAC_BITS is 1.0) is
// scaled to a bin as (pixel_code * bins) >> PIXEL_FRAC_BITS, clamped to the last
// bin in use, and that 32-bit counter goes up by one, saturating at its maximum.
// With op at read, the counter named by bin_index is returned on bin_count with
// done high for exactly one cycle, and the counter is cleared; an index beyond
// the store returns zero. No flow control exists on the result side: the
// receiver must take bin_count in the cycle in which done is high. The engine
// takes one command per clock when not busy: the counter memory is updated by a
// read-modify-write pipe with forwarding, so repeated hits on one bin do not
// stall. A read passes the front-end stage, the queue and the back-end read stage
// before bin_count is registered. After reset, busy stays high while the back end
// clears the counter memory one entry per cycle. The bins_in_use register (reset
// 256, zero acts as one, values above MAX_BINS act as MAX_BINS) may be written
// at any time the engine is idle; writing it does not touch the counters.
module gray_level_histogram #(
	parameter int MAX_BINS        = hgm_pkg::MAX_BINS_DEF,
	parameter int PIXEL_FRAC_BITS = hgm_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          bins_in_use_we,
	input  logic [hgm_pkg::BINS_W-1:0]    bins_in_use,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [PIXEL_FRAC_BITS:0]      pixel_code,
	input  logic [hgm_pkg::INDEX_W-1:0]   bin_index,
	output logic                          done,
	output logic [hgm_pkg::COUNT_W-1:0]   bin_count
);

	localparam int AW    = $clog2(MAX_BINS);
	localparam int DEPTH = hgm_pkg::QUEUE_DEPTH;
	localparam int QW    = $bits(hgm_pkg::hgm_ctl_t) + AW;
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic              accept;
	logic              pend;
	logic              push;
	hgm_pkg::hgm_ctl_t push_ctl;
	logic [AW-1:0]     push_addr;

	logic              pop;
	logic              q_empty;
	logic [QW-1:0]     q_rdata;
	logic [CNTW-1:0]   q_count;
	hgm_pkg::hgm_ctl_t q_ctl;
	logic [AW-1:0]     q_addr;
	logic              clearing;

	// Hold off new commands while the memory is being cleared, or when the queue
	// could not absorb the command already in the front end plus a new one.
	assign busy   = clearing
		|| (({1'b0, q_count} + (CNTW+1)'(pend)) >= (CNTW+1)'(DEPTH));
	assign accept = start && !busy;

	hgm_front #(
		.MAX_BINS        (MAX_BINS),
		.PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bins_we    (bins_in_use_we),
		.bins_wdata (bins_in_use),
		.accept     (accept),
		.op         (op),
		.pixel_code (pixel_code),
		.bin_index  (bin_index),
		.pend       (pend),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_addr  (push_addr)
	);

	hgm_fifo #(
		.WIDTH (QW),
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_ctl, push_addr}),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	assign q_ctl  = hgm_pkg::hgm_ctl_t'(q_rdata[QW-1:AW]);
	assign q_addr = q_rdata[AW-1:0];

	hgm_back #(
		.MAX_BINS (MAX_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_ctl     (q_ctl),
		.q_addr    (q_addr),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.bin_count (bin_count)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_count == CNTW'(DEPTH)) |-> pop)
		else $error("command queue overflow");

	a_accept_reaches_front: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend)
		else $error("transferred command lost in front end");

	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (busy && !q_empty == 1'b0))
		else $error("command queued during clearing pass");

endmodule

// File: rtl/hgm_fifo.sv
// Small synchronous queue between the front end and the back end of the
// histogram engine. Depends on nothing; width and depth come from the instantiator.
module hgm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

// File: rtl/hgm_front.sv
// Front end of the histogram engine: holds the bin-count register, scales each
// pixel to a bin number and classifies read commands. Uses hgm_pkg.
module hgm_front #(
	parameter int MAX_BINS        = hgm_pkg::MAX_BINS_DEF,
	parameter int PIXEL_FRAC_BITS = hgm_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             bins_we,
	input  logic [hgm_pkg::BINS_W-1:0]       bins_wdata,
	input  logic                             accept,
	input  logic                             op,
	input  logic [PIXEL_FRAC_BITS:0]         pixel_code,
	input  logic [hgm_pkg::INDEX_W-1:0]      bin_index,
	output logic                             pend,
	output logic                             push,
	output hgm_pkg::hgm_ctl_t                push_ctl,
	output logic [$clog2(MAX_BINS)-1:0]      push_addr
);

	localparam int CW = PIXEL_FRAC_BITS + 1;
	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int PW = CW + NW;
	localparam int AW = $clog2(MAX_BINS);
	localparam int EW = (NW > hgm_pkg::BINS_W) ? NW : hgm_pkg::BINS_W;

	logic [hgm_pkg::BINS_W-1:0]  bins_q;
	logic [EW-1:0]               bins_ext;
	logic [NW-1:0]               n_eff;

	logic                        v_s1;
	hgm_pkg::hgm_op_t            op_s1;
	logic [PW-1:0]               prod_s1;
	logic [NW-1:0]               n_s1;
	logic [hgm_pkg::INDEX_W-1:0] idx_s1;

	logic [NW:0]                 bin_raw;
	logic [NW-1:0]               n_m1;
	logic [NW-1:0]               bin_clamped;
	logic                        idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= hgm_pkg::BINS_RESET;
		end else if (bins_we) begin
			bins_q <= bins_wdata;
		end
	end

	// A count of zero acts as one bin; a count past the store acts as the full store.
	always_comb begin
		bins_ext = EW'(bins_q);
		if (bins_ext == '0) begin
			n_eff = NW'(1);
		end else if (bins_ext > EW'(MAX_BINS)) begin
			n_eff = NW'(MAX_BINS);
		end else begin
			n_eff = NW'(bins_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= hgm_pkg::hgm_op_t'(op);
			prod_s1 <= PW'(pixel_code) * PW'(n_eff);
			n_s1    <= n_eff;
			idx_s1  <= bin_index;
		end
	end

	// Codes at or above 1.0 land past the last bin and are pulled back into it.
	always_comb begin
		bin_raw = prod_s1[PW-1:PIXEL_FRAC_BITS];
		n_m1    = n_s1 - 1'b1;
		if (bin_raw > {1'b0, n_m1}) begin
			bin_clamped = n_m1;
		end else begin
			bin_clamped = bin_raw[NW-1:0];
		end
		idx_ok = EW'(idx_s1) < EW'(MAX_BINS);
	end

	always_comb begin
		push_ctl.op = op_s1;
		if (op_s1 == hgm_pkg::HGM_OP_READ) begin
			push_ctl.in_range = idx_ok;
			push_addr         = AW'(idx_s1);
		end else begin
			push_ctl.in_range = 1'b1;
			push_addr         = AW'(bin_clamped);
		end
	end

	assign push = v_s1;
	assign pend = v_s1;

endmodule

// File: rtl/hgm_back.sv
// Back end of the histogram engine: the bin counter memory, its clearing pass
// after reset, and the read-modify-write pipe with forwarding. Uses hgm_pkg.
module hgm_back #(
	parameter int MAX_BINS = hgm_pkg::MAX_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  hgm_pkg::hgm_ctl_t             q_ctl,
	input  logic [$clog2(MAX_BINS)-1:0]   q_addr,
	output logic                          pop,
	output logic                          clearing,
	output logic                          done,
	output logic [hgm_pkg::COUNT_W-1:0]   bin_count
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int NC = hgm_pkg::COUNT_W;

	logic [NC-1:0] mem_q [MAX_BINS];

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic              v_b1;
	hgm_pkg::hgm_op_t  op_b1;
	logic              rng_b1;
	logic [AW-1:0]     addr_b1;
	logic [NC-1:0]     rdata_b1;

	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [NC-1:0] fwd_data_q;

	logic          done_q;
	logic [NC-1:0] bin_count_q;

	logic [NC-1:0] old_cnt;
	logic [NC-1:0] wr_data;
	logic          wr_en;

	assign pop      = !q_empty && !clr_q;
	assign clearing = clr_q;

	// The write of the previous command lands at the same edge that reads the
	// current one, so that one write is forwarded.
	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_b1)) begin
			old_cnt = fwd_data_q;
		end else begin
			old_cnt = rdata_b1;
		end
		wr_en = v_b1 && rng_b1;
		if (op_b1 == hgm_pkg::HGM_OP_ACCUM) begin
			wr_data = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[addr_b1] <= wr_data;
		end
		if (pop) begin
			rdata_b1 <= mem_q[q_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			v_b1       <= 1'b0;
			fwd_v_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == AW'(MAX_BINS - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			v_b1    <= pop;
			fwd_v_q <= wr_en;
			done_q  <= v_b1 && (op_b1 == hgm_pkg::HGM_OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_b1   <= q_ctl.op;
			rng_b1  <= q_ctl.in_range;
			addr_b1 <= q_addr;
		end
		if (wr_en) begin
			fwd_addr_q <= addr_b1;
			fwd_data_q <= wr_data;
		end
		bin_count_q <= rng_b1 ? old_cnt : '0;
	end

	assign done      = done_q;
	assign bin_count = bin_count_q;

	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !v_b1)
		else $error("command in flight during clearing pass");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(v_b1 && op_b1 == hgm_pkg::HGM_OP_READ && rng_b1) |=> (fwd_v_q && fwd_data_q == '0))
		else $error("read did not clear its bin");

	a_accum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_b1 && op_b1 == hgm_pkg::HGM_OP_ACCUM) |=> (fwd_v_q && fwd_data_q != '0))
		else $error("accumulate left a zero counter");

endmodule

// File: sim/gray_level_histogram_check.sv
// Checker for the gray-level histogram engine: watches the command, register and
// result channels, keeps its own copy of the bin counters and compares each read.
// Depends on hgm_pkg.
module gray_level_histogram_check #(
	parameter int MAX_BINS        = hgm_pkg::MAX_BINS_DEF,
	parameter int PIXEL_FRAC_BITS = hgm_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        bins_in_use_we,
	input  logic [hgm_pkg::BINS_W-1:0]  bins_in_use,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        op,
	input  logic [PIXEL_FRAC_BITS:0]    pixel_code,
	input  logic [hgm_pkg::INDEX_W-1:0] bin_index,
	input  logic                        done,
	input  logic [hgm_pkg::COUNT_W-1:0] bin_count,
	output int                          pending,
	output int                          mismatches
);

	localparam logic [hgm_pkg::COUNT_W-1:0] COUNT_FULL = '1;

	logic [hgm_pkg::COUNT_W-1:0] bin_tally [MAX_BINS];
	logic [hgm_pkg::BINS_W-1:0]  bins_reg;
	logic [hgm_pkg::COUNT_W-1:0] expected_counts [$];
	logic [hgm_pkg::COUNT_W-1:0] want;
	int                          slot;
	int                          i;

	// Bin that a gray level falls into under the current register setting.
	function automatic int bin_of_code(logic [PIXEL_FRAC_BITS:0] code,
		logic [hgm_pkg::BINS_W-1:0] reg_val);
		int         n;
		logic [47:0] prod;
		logic [47:0] bin;
		n = int'(reg_val);
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_BINS) begin
			n = MAX_BINS;
		end
		prod = 48'(code) * 48'(n);
		bin  = prod >> PIXEL_FRAC_BITS;
		if (bin > 48'(n - 1)) begin
			bin = 48'(n - 1);
		end
		return int'(bin);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < MAX_BINS; i++) begin
				bin_tally[i] = '0;
			end
			bins_reg = hgm_pkg::BINS_RESET;
			expected_counts.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			if (done) begin
				if (expected_counts.size() == 0) begin
					$error("bin_count: no read outstanding, actual %0d", bin_count);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (bin_count !== want) begin
						$error("bin_count: expected %0d, actual %0d", want, bin_count);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				if (op == hgm_pkg::HGM_OP_ACCUM) begin
					slot = bin_of_code(pixel_code, bins_reg);
					if (bin_tally[slot] != COUNT_FULL) begin
						bin_tally[slot] = bin_tally[slot] + 1'b1;
					end
				end else begin
					slot = int'(bin_index);
					if (slot < MAX_BINS) begin
						expected_counts.push_back(bin_tally[slot]);
						bin_tally[slot] = '0;
					end else begin
						expected_counts.push_back('0);
					end
				end
			end
			// A register write takes effect for commands after this edge.
			if (bins_in_use_we) begin
				bins_reg = bins_in_use;
			end
			pending = expected_counts.size();
		end
	end

endmodule

// File: sim/gray_level_histogram_test.sv
// Testbench top for the gray-level histogram engine: clock, reset, command and
// register stimulus, and the final verdict. Uses hgm_pkg, gray_level_histogram
// and gray_level_histogram_check.
module gray_level_histogram_test;

	localparam int FRAC      = hgm_pkg::PIXEL_FRAC_BITS_DEF;
	localparam int CODE_ONE  = 1 << FRAC;
	localparam int CODE_TOP  = (1 << (FRAC + 1)) - 1;
	localparam int RANDOM_ITEMS = 900;
	// Accumulates give no result, so after the last read has come back we still
	// let this many cycles pass before touching the register.
	localparam int SETTLE = 8;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          bins_in_use_we;
	logic [hgm_pkg::BINS_W-1:0]    bins_in_use;
	logic                          start;
	logic                          busy;
	hgm_pkg::hgm_op_t              op;
	logic [FRAC:0]                 pixel_code;
	logic [hgm_pkg::INDEX_W-1:0]   bin_index;
	logic                          done;
	logic [hgm_pkg::COUNT_W-1:0]   bin_count;
	int                            pending;
	int                            mismatches;

	// Shaping state for the stimulus only; the checker keeps the real model.
	int                   bins_now;
	bit                   steady;
	int                   sent;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	gray_level_histogram DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.bins_in_use_we (bins_in_use_we),
		.bins_in_use    (bins_in_use),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.pixel_code     (pixel_code),
		.bin_index      (bin_index),
		.done           (done),
		.bin_count      (bin_count)
	);

	gray_level_histogram_check checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.bins_in_use_we (bins_in_use_we),
		.bins_in_use    (bins_in_use),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.pixel_code     (pixel_code),
		.bin_index      (bin_index),
		.done           (done),
		.bin_count      (bin_count),
		.pending        (pending),
		.mismatches     (mismatches)
	);

	// Sender gaps: mostly none or short, now and then a long one. Inside a
	// steady stretch no gap is drawn, so back-to-back transfers hit the
	// forwarding paths of the counter pipe.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Present one command and hold it until the engine takes it. Busy is looked
	// at on the falling edge, where it is settled, and the transfer then happens
	// on the following rising edge. Start stays high into the next command
	// unless a gap is drawn.
	task automatic transfer_cmd(hgm_pkg::hgm_op_t o, int code, int idx);
		int g;
		start      <= 1'b1;
		op         <= o;
		pixel_code <= code[FRAC:0];
		bin_index  <= idx[hgm_pkg::INDEX_W-1:0];
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent++;
		g = pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_pixel(int code);
		transfer_cmd(hgm_pkg::HGM_OP_ACCUM, code, $urandom_range(0, 255));
	endtask

	task automatic send_read(int idx);
		transfer_cmd(hgm_pkg::HGM_OP_READ, $urandom_range(0, CODE_TOP), idx);
	endtask

	// Let every outstanding read come back, then give the pipe time to finish
	// any accumulate still in flight.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The register is only written with the engine idle; the counters are left
	// alone by the write, so later reads may return counts from the old setting.
	task automatic write_bins(int value);
		drain();
		bins_in_use_we <= 1'b1;
		bins_in_use    <= value[hgm_pkg::BINS_W-1:0];
		@(posedge clk);
		bins_in_use_we <= 1'b0;
		bins_now = value % (1 << hgm_pkg::BINS_W);
		if (bins_now == 0) begin
			bins_now = 1;
		end
		if (bins_now > hgm_pkg::MAX_BINS_DEF) begin
			bins_now = hgm_pkg::MAX_BINS_DEF;
		end
	endtask

	// Gray level for random traffic. Codes near a bin edge catch rounding of
	// the scale step, exactly 1.0 and codes above it exercise the clamp.
	function automatic int pick_code(int last_code);
		int r;
		int k;
		int c;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return last_code;
		end else if (r < 55) begin
			return $urandom_range(0, CODE_ONE);
		end else if (r < 75) begin
			k = $urandom_range(0, bins_now);
			c = (k * CODE_ONE) / bins_now + $urandom_range(0, 2) - 1;
			if (c < 0) begin
				c = 0;
			end
			return c;
		end else if (r < 85) begin
			return CODE_ONE;
		end else if (r < 92) begin
			return 0;
		end
		return $urandom_range(CODE_ONE + 1, CODE_TOP);
	endfunction

	// One image: a run of pixels with a few stray reads mixed in, then a
	// read-out of the histogram. Small settings are read out whole, a few
	// indexes past the last bin in use included; large ones only in part.
	task automatic send_frame();
		int pixels;
		int code;
		int j;
		pixels = $urandom_range(8, 64);
		code = $urandom_range(0, CODE_ONE);
		for (j = 0; j < pixels; j++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_read($urandom_range(0, 255));
			end else begin
				code = pick_code(code);
				send_pixel(code);
			end
		end
		if (bins_now <= 32) begin
			for (j = 0; j < bins_now; j++) begin
				send_read(j);
			end
			repeat ($urandom_range(0, 2)) send_read($urandom_range(bins_now, 255));
		end else begin
			repeat (16) send_read($urandom_range(0, bins_now - 1));
		end
	endtask

	// Random commands with no structure at all.
	task automatic send_noise();
		int j;
		int count;
		count = $urandom_range(20, 40);
		for (j = 0; j < count; j++) begin
			if ($urandom_range(0, 1) == 0) begin
				send_pixel($urandom_range(0, CODE_TOP));
			end else begin
				send_read($urandom_range(0, 255));
			end
		end
	endtask

	function automatic int pick_setting();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			case ($urandom_range(0, 5))
				0: return 0;
				1: return 1;
				2: return 2;
				3: return 256;
				4: return 257;
				default: return 511;
			endcase
		end else if (r < 75) begin
			return $urandom_range(1, 16);
		end
		return $urandom_range(0, 511);
	endfunction

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		bins_in_use_we <= 1'b0;
		bins_in_use    <= hgm_pkg::BINS_RESET;
		start          <= 1'b0;
		op             <= hgm_pkg::HGM_OP_ACCUM;
		pixel_code     <= '0;
		bin_index      <= '0;
		bins_now = hgm_pkg::MAX_BINS_DEF;
		steady   = 1'b0;
		sent     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// The engine clears its counter memory after reset and holds busy high
		// meanwhile; nothing is sent until that pass is over.
		do @(negedge clk); while (busy);
		@(posedge clk);

		// Directed part, at the reset setting of 256 bins. Zero, the top of
		// the first bin, the start of the second, the top of the last, exactly
		// 1.0 and the all-ones code, which is clamped into the last bin.
		steady = 1'b1;
		send_pixel(0);
		send_pixel(255);
		send_pixel(256);
		send_pixel(256);
		send_read(1);
		send_pixel(256);
		send_read(1);
		send_pixel(CODE_ONE - 1);
		send_pixel(CODE_ONE);
		send_pixel(CODE_TOP);
		send_read(0);
		send_read(255);
		send_read(255);
		send_read(8'hAA);
		send_read(8'h55);
		// A zero setting acts as a single bin; a read above the bins in use
		// still returns and clears what the store holds there.
		write_bins(0);
		send_pixel(CODE_ONE);
		send_pixel(12345);
		send_pixel(0);
		send_read(0);
		send_read(200);
		// Settings above the store act as the full store.
		write_bins(511);
		send_pixel(CODE_ONE);
		send_read(255);
		write_bins(1);
		send_pixel(CODE_TOP);
		send_read(0);
		steady = 1'b0;

		// Random part. Saturation of a counter needs more than four billion
		// pixels in one bin and lies beyond any run of this length.
		while (sent < RANDOM_ITEMS) begin
			write_bins(pick_setting());
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				send_noise();
			end else begin
				send_frame();
			end
		end
		steady = 1'b0;

		drain();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
